FILE: hw/rtl/rkc_pkg.sv
// rkc_pkg: shared types and constants for the RGB kernel convolution unit.
// No dependencies; every other file in hw/rtl depends on this package.
package rkc_pkg;

  localparam int CFG_W       = 11;  // widest configuration register
  localparam int CFG_IDX_W   = 2;
  localparam int DIM_W       = 11;
  localparam int KSIZE_W     = 3;
  localparam int COEF_IDX_W  = 3;
  localparam int COEF_W      = 16;
  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 3 * CHAN_W;
  localparam int OUT_POS_W   = 10;
  localparam int POS_W       = 12;  // holds any row or column up to 4095
  localparam int EDIM_W      = POS_W + 1;
  localparam int SLOT_W      = 4;   // line buffer slot, up to 16 slots
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = 2;
  localparam int Q_CNT_W     = Q_AW + 1;
  localparam logic [CHAN_W-1:0] SAT_MAX = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 2'd2;

  localparam logic ACT_COEF  = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [KSIZE_W-1:0] kernel_size;
  } cfg_t;

  typedef struct packed {
    logic                     action;
    logic [COEF_IDX_W-1:0]    coef_row;
    logic [COEF_IDX_W-1:0]    coef_col;
    logic signed [COEF_W-1:0] coef_value;
    logic [CHAN_W-1:0]        red_in;
    logic [CHAN_W-1:0]        green_in;
    logic [CHAN_W-1:0]        blue_in;
  } in_item_t;

  typedef struct packed {
    logic                 valid_res;
    logic [OUT_POS_W-1:0] out_row;
    logic [OUT_POS_W-1:0] out_col;
    logic [CHAN_W-1:0]    red_out;
    logic [CHAN_W-1:0]    green_out;
    logic [CHAN_W-1:0]    blue_out;
  } out_item_t;

  // Classified beat handed from the front end to the datapath
  typedef struct packed {
    logic                     is_pix;
    logic [COEF_IDX_W-1:0]    coef_row;
    logic [COEF_IDX_W-1:0]    coef_col;
    logic signed [COEF_W-1:0] coef_value;
    logic [PIX_W-1:0]         pix;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic [SLOT_W-1:0]        slot;
  } q_item_t;

endpackage

FILE: hw/rtl/rkc_in_if.sv
// rkc_in_if: valid/ready channel carrying input beats.
// Depends on rkc_pkg for the payload type.
interface rkc_in_if;
  logic               valid;
  logic               ready;
  rkc_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rkc_out_if.sv
// rkc_out_if: valid/ready channel carrying filtered results.
// Depends on rkc_pkg for the payload type.
interface rkc_out_if;
  logic               valid;
  logic               ready;
  rkc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rkc_front.sv
// rkc_front: accepts input beats, tags pixels with row, column and line slot.
// Depends on rkc_pkg and rkc_in_if; feeds rkc_queue.
module rkc_front #(
  parameter int MAX_KERNEL = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rkc_pkg::cfg_t    cfg,
  rkc_in_if.sink           in_ch,
  input  logic             q_full,
  output logic             push,
  output rkc_pkg::q_item_t push_data
);
  import rkc_pkg::*;

  localparam int LINE_ROWS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;

  logic [POS_W-1:0]  row_r, row_nxt;
  logic [POS_W-1:0]  col_r, col_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [EDIM_W-1:0] w_eff, h_eff;
  logic              pix_beat;

  function automatic logic [EDIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic [EDIM_W-1:0] r;
    r = EDIM_W'(v);
    if (v == '0) r = EDIM_W'(1);
    else if (r > EDIM_W'(maxv)) r = EDIM_W'(maxv);
    return r;
  endfunction

  assign w_eff = eff_dim(cfg.image_width, MAX_WIDTH);
  assign h_eff = eff_dim(cfg.image_height, MAX_HEIGHT);

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign pix_beat    = push && (in_ch.data.action == ACT_PIXEL);

  always_comb begin
    push_data.is_pix     = (in_ch.data.action == ACT_PIXEL);
    push_data.coef_row   = in_ch.data.coef_row;
    push_data.coef_col   = in_ch.data.coef_col;
    push_data.coef_value = in_ch.data.coef_value;
    push_data.pix        = {in_ch.data.red_in, in_ch.data.green_in, in_ch.data.blue_in};
    push_data.row        = row_r;
    push_data.col        = col_r;
    push_data.slot       = slot_r;
  end

  // Raster counters; the slot follows row mod line count without a divider
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    slot_nxt = slot_r;
    if (pix_beat) begin
      if ((EDIM_W'(col_r) + EDIM_W'(1)) >= w_eff) begin
        col_nxt = '0;
        if ((EDIM_W'(row_r) + EDIM_W'(1)) >= h_eff) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = row_r + POS_W'(1);
          slot_nxt = (slot_r == SLOT_W'(LINE_ROWS - 1)) ? '0 : slot_r + SLOT_W'(1);
        end
      end else begin
        col_nxt = col_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

FILE: hw/rtl/rkc_queue.sv
// rkc_queue: short FIFO of classified beats between front end and datapath.
// Depends on rkc_pkg.
module rkc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rkc_pkg::q_item_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output rkc_pkg::q_item_t q_data
);
  import rkc_pkg::*;

  q_item_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + Q_CNT_W'(1);
    else if (!push && pop) cnt_nxt = cnt_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH)) else $error("queue count above depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + Q_CNT_W'(1))
    else $error("queue count lost a beat");

endmodule

FILE: hw/rtl/rkc_back.sv
// rkc_back: line buffers, window, coefficient bank, multiply/add pipeline, output register.
// Depends on rkc_pkg and rkc_out_if; fed by rkc_queue.
module rkc_back #(
  parameter int MAX_KERNEL = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int COEF_FRAC  = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rkc_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  rkc_pkg::q_item_t q_data,
  output logic             q_pop,
  rkc_out_if.source        out_ch
);
  import rkc_pkg::*;

  localparam int LINE_ROWS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int SW        = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
  localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int KW        = $clog2(MAX_KERNEL + 1);
  localparam int GROW      = $clog2(MAX_KERNEL + 1);
  localparam int PROD_W    = COEF_W + CHAN_W + 1;
  localparam int ROW_W     = PROD_W + GROW;
  localparam int ACC_W     = ROW_W + GROW;

  typedef struct packed {
    logic                 rv;
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
  } meta_t;

  logic                     adv;
  logic [KW-1:0]            k_eff;
  logic [KW-1:0]            km1;
  logic [KW-1:0]            hk;

  logic                     s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, out_v_r;
  q_item_t                  s1_r;
  logic [PIX_W-1:0]         rd_r   [LINE_ROWS];
  logic [PIX_W-1:0]         newcol [MAX_KERNEL];
  logic [PIX_W-1:0]         win_r  [MAX_KERNEL][MAX_KERNEL];
  logic signed [COEF_W-1:0] coef_r [MAX_KERNEL][MAX_KERNEL];
  meta_t                    s2_m_r, s3_m_r, s4_m_r, s5_m_r, s1_meta;
  logic signed [PROD_W-1:0] prod_r [3][MAX_KERNEL][MAX_KERNEL];
  logic signed [ROW_W-1:0]  rsum_r [3][MAX_KERNEL];
  logic signed [ACC_W-1:0]  tot_r  [3];
  out_item_t                out_r;

  function automatic logic signed [PROD_W-1:0] mul(input logic signed [COEF_W-1:0] c,
                                                   input logic [CHAN_W-1:0] p);
    logic signed [PROD_W-1:0] ce;
    logic signed [PROD_W-1:0] pe;
    ce = PROD_W'(c);
    pe = $signed(PROD_W'({1'b0, p}));
    return ce * pe;
  endfunction

  function automatic logic [CHAN_W-1:0] scale(input logic signed [ACC_W-1:0] s);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] sh;
    mag = s[ACC_W-1] ? ACC_W'(-s) : ACC_W'(s);
    sh  = mag >> COEF_FRAC;
    return (sh > ACC_W'(SAT_MAX)) ? SAT_MAX : sh[CHAN_W-1:0];
  endfunction

  // Effective kernel: clamp, drop even sizes by one, zero acts as one
  always_comb begin
    logic [KW:0] kt;
    kt = (KW + 1)'(cfg.kernel_size);
    if (kt > (KW + 1)'(MAX_KERNEL)) kt = (KW + 1)'(MAX_KERNEL);
    if (!kt[0] && (kt != '0)) kt = kt - (KW + 1)'(1);
    if (kt == '0) kt = (KW + 1)'(1);
    k_eff = kt[KW-1:0];
  end
  assign km1 = k_eff - KW'(1);
  assign hk  = k_eff >> 1;

  // Whole pipeline advances unless the result register is stuck
  assign adv   = !out_v_r || out_ch.ready;
  assign q_pop = adv && q_valid;

  // One memory per stored row; read before write returns the older row
  for (genvar g = 0; g < LINE_ROWS; g++) begin : g_line
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (q_pop) begin
        rd_r[g] <= mem[q_data.col[AW-1:0]];
        if (q_data.is_pix && (q_data.slot == SLOT_W'(g))) begin
          mem[q_data.col[AW-1:0]] <= q_data.pix;
        end
      end
    end
  end

  assign newcol[0] = s1_r.pix;
  for (genvar gi = 1; gi < MAX_KERNEL; gi++) begin : g_col
    localparam int OFF = gi % LINE_ROWS;
    logic [SLOT_W-1:0] sel;
    assign sel = (s1_r.slot >= SLOT_W'(OFF)) ? s1_r.slot - SLOT_W'(OFF)
                                             : s1_r.slot + SLOT_W'(LINE_ROWS - OFF);
    assign newcol[gi] = rd_r[sel[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (q_pop) s1_r <= q_data;
  end

  // Shift the window right and drop in the new column
  always_ff @(posedge clk) begin
    if (adv && s1_v_r && s1_r.is_pix) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        for (int j = MAX_KERNEL - 1; j > 0; j--) win_r[i][j] <= win_r[i][j-1];
        win_r[i][0] <= newcol[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_KERNEL; i++)
        for (int j = 0; j < MAX_KERNEL; j++) coef_r[i][j] <= '0;
    end else if (adv && s1_v_r && !s1_r.is_pix) begin
      for (int i = 0; i < MAX_KERNEL; i++)
        for (int j = 0; j < MAX_KERNEL; j++)
          if ((32'(s1_r.coef_row) == i) && (32'(s1_r.coef_col) == j))
            coef_r[i][j] <= s1_r.coef_value;
    end
  end

  always_comb begin
    s1_meta.rv  = s1_r.is_pix && (s1_r.row >= POS_W'(km1)) && (s1_r.col >= POS_W'(km1));
    s1_meta.row = OUT_POS_W'(s1_r.row - POS_W'(hk));
    s1_meta.col = OUT_POS_W'(s1_r.col - POS_W'(hk));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_m_r <= s1_meta;
      s3_m_r <= s2_m_r;
      s4_m_r <= s3_m_r;
      s5_m_r <= s4_m_r;
      // products, masked to the kernel in use
      for (int ch = 0; ch < 3; ch++)
        for (int i = 0; i < MAX_KERNEL; i++)
          for (int j = 0; j < MAX_KERNEL; j++)
            prod_r[ch][i][j] <= (s2_m_r.rv && (i < 32'(k_eff)) && (j < 32'(k_eff)))
              ? mul(coef_r[i][j], win_r[i][j][PIX_W-1-CHAN_W*ch -: CHAN_W]) : '0;
      for (int ch = 0; ch < 3; ch++) begin
        for (int i = 0; i < MAX_KERNEL; i++) begin
          logic signed [ROW_W-1:0] acc;
          acc = '0;
          for (int j = 0; j < MAX_KERNEL; j++) acc = acc + ROW_W'(prod_r[ch][i][j]);
          rsum_r[ch][i] <= acc;
        end
      end
      for (int ch = 0; ch < 3; ch++) begin
        logic signed [ACC_W-1:0] tacc;
        tacc = '0;
        for (int i = 0; i < MAX_KERNEL; i++) tacc = tacc + ACC_W'(rsum_r[ch][i]);
        tot_r[ch] <= tacc;
      end
      out_r.valid_res <= s5_m_r.rv;
      out_r.out_row   <= s5_m_r.rv ? s5_m_r.row : '0;
      out_r.out_col   <= s5_m_r.rv ? s5_m_r.col : '0;
      out_r.red_out   <= s5_m_r.rv ? scale(tot_r[0]) : '0;
      out_r.green_out <= s5_m_r.rv ? scale(tot_r[1]) : '0;
      out_r.blue_out  <= s5_m_r.rv ? scale(tot_r[2]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= q_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      out_v_r <= s5_v_r;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

endmodule

FILE: hw/rtl/rgb_kernel_convolution_unit.sv
// Path from the accepting edge: queue, s1 register, window, products, row sums, totals, result register.
// Throughput: one beat per cycle (pixel or coefficient write) unless the output stalls; each beat yields one result.
// The multiply/add pipeline and a 4-entry queue sit between input and output handshakes.
// Reset (rst_n, synchronous) sets width 640, height 480, kernel 3, clears coefficients,
// counters and valid bits; line buffers are not cleared.
module rgb_kernel_convolution_unit #(
  parameter int MAX_KERNEL = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int COEF_FRAC  = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rkc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rkc_pkg::CFG_W-1:0]        cfg_wdata,
  rkc_in_if.sink                           in_ch,
  rkc_out_if.source                        out_ch
);
  import rkc_pkg::*;

  cfg_t    cfg_r;
  logic    q_full, push, pop, q_valid;
  q_item_t push_data, q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= DIM_W'(640);
      cfg_r.image_height <= DIM_W'(480);
      cfg_r.kernel_size  <= KSIZE_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_wdata[DIM_W-1:0];
        REG_KERNEL_SIZE:  cfg_r.kernel_size  <= cfg_wdata[KSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  rkc_front #(
    .MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk, .rst_n, .cfg(cfg_r), .in_ch, .q_full, .push, .push_data
  );

  rkc_queue u_queue (
    .clk, .rst_n, .push, .push_data, .full(q_full), .pop, .q_valid, .q_data
  );

  rkc_back #(
    .MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH), .COEF_FRAC(COEF_FRAC)
  ) u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_valid, .q_data, .q_pop(pop), .out_ch
  );

endmodule

FILE: dv/rgb_kernel_convolution_unit_test.sv
// Self-checking testbench for rgb_kernel_convolution_unit: directed table, then random frames.
// Depends on rkc_pkg, rkc_in_if, rkc_out_if and the unit itself.
module rgb_kernel_convolution_unit_test;
  import rkc_pkg::*;

  localparam int KMAX = 7;
  localparam int WMAX = 1024;
  localparam int HMAX = 1024;
  localparam int FRAC = 12;
  localparam int ROWS_HELD = KMAX - 1;
  localparam int SETTLE = 12;

  typedef struct {
    in_item_t  beat;
    bit        typed;
    out_item_t want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  rkc_in_if  in_ch ();
  rkc_out_if out_ch ();

  rgb_kernel_convolution_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Mirror of the unit's state
  logic signed [COEF_W-1:0] coef_m [KMAX][KMAX];
  logic [PIX_W-1:0] lines_m [ROWS_HELD][WMAX];
  logic [PIX_W-1:0] win_m [KMAX][KMAX];
  int unsigned row_m, col_m;
  logic [DIM_W-1:0] width_m, height_m;
  logic [KSIZE_W-1:0] ksize_m;

  out_item_t filtered_q[$];
  int errors = 0;

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic int unsigned eff_kernel(logic [KSIZE_W-1:0] v);
    int unsigned k;
    k = v;
    if (k > KMAX) k = KMAX;
    if (k[0] == 1'b0 && k > 0) k = k - 1;
    if (k == 0) k = 1;
    return k;
  endfunction

  function automatic logic [CHAN_W-1:0] clip_plane(longint s);
    longint m;
    m = (s < 0) ? -s : s;
    m = m >>> FRAC;
    return (m > 255) ? SAT_MAX : m[CHAN_W-1:0];
  endfunction

  // Advance the mirror by one beat and return the filtered pixel it produces
  function automatic out_item_t filter_beat(in_item_t b);
    out_item_t o;
    int unsigned r, c, k, h, base, slot;
    longint sr, sg, sb, cv;
    logic [PIX_W-1:0] p;
    o = '0;
    sr = 0; sg = 0; sb = 0;
    if (b.action == ACT_COEF) begin
      if (b.coef_row < KMAX && b.coef_col < KMAX) coef_m[b.coef_row][b.coef_col] = b.coef_value;
      return o;
    end
    r = row_m;
    c = col_m;
    for (int i = 0; i < KMAX; i++)
      for (int j = KMAX - 1; j > 0; j--) win_m[i][j] = win_m[i][j-1];
    win_m[0][0] = {b.red_in, b.green_in, b.blue_in};
    base = r % ROWS_HELD;
    for (int i = 1; i < KMAX; i++) begin
      slot = (base + ROWS_HELD - (i % ROWS_HELD)) % ROWS_HELD;
      win_m[i][0] = lines_m[slot][c];
    end
    lines_m[base][c] = win_m[0][0];
    k = eff_kernel(ksize_m);
    h = k / 2;
    if (r >= 2 * h && c >= 2 * h) begin
      for (int i = 0; i < k; i++)
        for (int j = 0; j < k; j++) begin
          cv = coef_m[i][j];
          p = win_m[i][j];
          sr += cv * longint'(p[23:16]);
          sg += cv * longint'(p[15:8]);
          sb += cv * longint'(p[7:0]);
        end
      o.valid_res = 1'b1;
      o.out_row = OUT_POS_W'(r - h);
      o.out_col = OUT_POS_W'(c - h);
      o.red_out = clip_plane(sr);
      o.green_out = clip_plane(sg);
      o.blue_out = clip_plane(sb);
    end
    if (c + 1 >= eff_dim(width_m, WMAX)) begin
      col_m = 0;
      row_m = (r + 1 >= eff_dim(height_m, HMAX)) ? 0 : r + 1;
    end else begin
      col_m = c + 1;
    end
    return o;
  endfunction

  function automatic in_item_t coef_beat(int unsigned r, int unsigned c, logic [15:0] v);
    in_item_t b;
    b = in_item_t'({$urandom, $urandom});
    b.action = ACT_COEF;
    b.coef_row = COEF_IDX_W'(r);
    b.coef_col = COEF_IDX_W'(c);
    b.coef_value = v;
    return b;
  endfunction

  function automatic in_item_t pix_beat(logic [7:0] r, logic [7:0] g, logic [7:0] bl);
    in_item_t b;
    b = in_item_t'({$urandom, $urandom});
    b.action = ACT_PIXEL;
    b.red_in = r;
    b.green_in = g;
    b.blue_in = bl;
    return b;
  endfunction

  // Sender: hold the beat until accepted, then queue what it should produce
  bit send_burst = 1'b0;
  task automatic send(in_item_t b, bit typed, out_item_t want);
    int unsigned gap;
    out_item_t got;
    if ($urandom_range(0, 49) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= b;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    got = filter_beat(b);
    filtered_q.push_back(typed ? want : got);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_frame(int unsigned w, int unsigned ht, int unsigned k);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;  cfg_wdata <= CFG_W'(w);  @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT; cfg_wdata <= CFG_W'(ht); @(posedge clk);
    cfg_index <= REG_KERNEL_SIZE;  cfg_wdata <= CFG_W'(k);  @(posedge clk);
    cfg_we <= 1'b0;
    width_m = DIM_W'(w);
    height_m = DIM_W'(ht);
    ksize_m = KSIZE_W'(k);
  endtask

  // Whole frames only, so the line buffer is never read outside the current frame
  task automatic run_frames(int unsigned frames);
    int unsigned n;
    logic [15:0] v;
    n = frames * eff_dim(width_m, WMAX) * eff_dim(height_m, HMAX);
    while (n > 0) begin
      if ($urandom_range(0, 99) < 15) begin
        v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192) - 4096);
        send(coef_beat($urandom_range(0, 7), $urandom_range(0, 7), v), 1'b0, '0);
      end else begin
        send(pix_beat(8'($urandom), 8'($urandom), 8'($urandom)), 1'b0, '0);
        n--;
      end
    end
  endtask

  // Receiver with random stalls
  bit take_burst = 1'b0;
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 49) == 0) take_burst = ~take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk); while (!out_ch.valid);
      @(posedge clk);
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t w, g;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      g = out_ch.data;
      if (filtered_q.size() == 0) begin
        $error("result beat with nothing expected: %h", g);
        errors++;
      end else begin
        w = filtered_q.pop_front();
        check_field("valid_res", w.valid_res, g.valid_res);
        check_field("out_row", w.out_row, g.out_row);
        check_field("out_col", w.out_col, g.out_col);
        check_field("red_out", w.red_out, g.red_out);
        check_field("green_out", w.green_out, g.green_out);
        check_field("blue_out", w.blue_out, g.blue_out);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("rgb_kernel_convolution_unit_test: FAIL");
    $finish;
  end

  table_row_t steps [$];

  initial begin
    table_row_t t;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    for (int i = 0; i < KMAX; i++)
      for (int j = 0; j < KMAX; j++) begin
        coef_m[i][j] = '0;
        win_m[i][j] = '0;
      end
    foreach (lines_m[i, j]) lines_m[i][j] = '0;
    row_m = 0; col_m = 0;
    width_m = DIM_W'(640); height_m = DIM_W'(480); ksize_m = KSIZE_W'(3);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: coefficient writes (extremes, ignored indexes), then one 4x4 frame
    set_frame(4, 4, 3);
    t.want = '0;
    t.typed = 1'b1;
    t.beat = coef_beat(1, 1, 16'h1000); steps.push_back(t);
    t.beat = coef_beat(0, 0, 16'h7FFF); steps.push_back(t);
    t.beat = coef_beat(2, 2, 16'h8000); steps.push_back(t);
    t.beat = coef_beat(7, 3, 16'h7FFF); steps.push_back(t);
    t.beat = coef_beat(3, 7, 16'h8000); steps.push_back(t);
    t.beat = coef_beat(7, 7, 16'h1234); steps.push_back(t);
    t.beat = coef_beat(6, 6, 16'h0001); steps.push_back(t);
    for (int i = 0; i < 16; i++) begin
      t.typed = (i < 4);  // first row is border
      case (i % 4)
        0: t.beat = pix_beat(8'd0, 8'd0, 8'd0);
        1: t.beat = pix_beat(8'd255, 8'd255, 8'd255);
        2: t.beat = pix_beat(8'd255, 8'd0, 8'd128);
        default: t.beat = pix_beat(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      steps.push_back(t);
    end
    foreach (steps[i]) send(steps[i].beat, steps[i].typed, steps[i].want);

    // Random: fixed corners of the kernel setting, then random small frames
    set_frame(9, 9, 7);  run_frames(2);
    set_frame(5, 3, 0);  run_frames(2);
    set_frame(6, 6, 4);  run_frames(1);
    for (int p = 0; p < 12; p++) begin
      set_frame($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(0, 7));
      run_frames($urandom_range(1, 2));
    end

    drain();
    if (errors == 0) begin
      $display("rgb_kernel_convolution_unit_test: PASS");
    end else begin
      $display("rgb_kernel_convolution_unit_test: FAIL");
    end
    $finish;
  end

endmodule
